// ===== rtl/core/humidity_temperature_compensation_assert.svh =====
// Assertion shorthands shared by the conversion block.
`ifndef HUMIDITY_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define HUMIDITY_TEMPERATURE_COMPENSATION_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define HTC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define HTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/htc_pkg.sv =====
package htc_pkg;

  // Item kind codes
  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_HUM  = 1'b1;

  // Register index codes (address bit 2)
  localparam logic REG_LOW_RES     = 1'b0;
  localparam logic REG_TEMP_OFFSET = 1'b1;

  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int OFFS_W   = 13;
  localparam int RAW_MAXW = 16;
  localparam int T_W      = 18;
  localparam int OUT_W    = 17;
  localparam int MUL_W    = 30;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 40;
  localparam int PRE_SHIFT   = 5;
  localparam int Y_W         = 28;
  localparam int RECIP_SHIFT = 40;
  localparam int Q_W         = 17;

  localparam logic [RAW_MAXW-1:0] TEMP_RAW_LIMIT = 16'd14000;
  localparam logic [RAW_MAXW-1:0] HUM_RAW_LIMIT  = 16'd2567;

  localparam logic signed [OFFS_W-1:0] OFFSET_RESET = -13'sd3966;

  // Humidity law in units of 1e-7 percent: N = BIAS + S*(A - B*S) + corr
  localparam logic signed [MUL_W-1:0] COEF_A_HI = 30'sd6480000;
  localparam logic signed [MUL_W-1:0] COEF_A_LO = 30'sd405000;
  localparam logic signed [MUL_W-1:0] COEF_B_HI = 30'sd7200;
  localparam logic signed [MUL_W-1:0] COEF_B_LO = 30'sd28;
  localparam logic [2:0] C_SHIFT_HI = 3'd7;
  localparam logic [2:0] C_SHIFT_LO = 3'd3;
  localparam logic signed [MUL_W-1:0] T1_SCALED = 30'sd1000;
  localparam logic signed [T_W:0]     T_REF     = 19'sd2500;
  localparam logic signed [ACC_W-1:0] N_BIAS    = -40'sd40000000;
  localparam logic signed [ACC_W-1:0] HALF      = 40'sd50000;

  // Quotient of 65537 already saturates either way, so clamp the dividend there.
  localparam logic [ACC_W-1:0] DIV_CLAMP = 40'd6553700000;
  // ceil(2^40 / 3125): floor(y / 3125) for every y below 2^28
  localparam logic signed [MUL_W-1:0] RECIP = 30'sd351843721;

  localparam logic signed [T_W-1:0] SAT_HI = 18'sd65535;
  localparam logic signed [T_W-1:0] SAT_LO = -18'sd65536;

  typedef struct packed {
    logic                     low_res;
    logic signed [OFFS_W-1:0] temp_offset;
  } cfg_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_QUAD   = 8'b0000_0100,
    S_CORR   = 8'b0000_1000,
    S_SUM    = 8'b0001_0000,
    S_ROUND  = 8'b0010_0000,
    S_SCALE  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } seq_state_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [T_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[OUT_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/htc_mul.sv =====
module htc_mul (
  input  logic                              clk,
  input  logic signed [htc_pkg::MUL_W-1:0]  a,
  input  logic signed [htc_pkg::MUL_W-1:0]  b,
  output logic signed [htc_pkg::PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/core/htc_cfg.sv =====
module htc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [htc_pkg::ADDR_W-1:0]   paddr,
  input  logic [htc_pkg::DATA_W-1:0]   pwdata,
  output logic [htc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output htc_pkg::cfg_t                cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_res     <= 1'b0;
      cfg.temp_offset <= htc_pkg::OFFSET_RESET;
    end else if (wr) begin
      case (paddr[2])
        htc_pkg::REG_LOW_RES:     cfg.low_res     <= pwdata[0];
        htc_pkg::REG_TEMP_OFFSET: cfg.temp_offset <= $signed(pwdata[htc_pkg::OFFS_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      htc_pkg::REG_LOW_RES:
        prdata = {{(htc_pkg::DATA_W-1){1'b0}}, cfg.low_res};
      htc_pkg::REG_TEMP_OFFSET:
        prdata = {{(htc_pkg::DATA_W-htc_pkg::OFFS_W){1'b0}}, cfg.temp_offset};
      default:
        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/humidity_temperature_compensation.sv =====
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+---------------------------------
// input     | in        | in_valid / in_stall | kind, raw_value
// result    | out       | out_valid/out_stall | result_kind, accepted, value
// register  | in/out    | APB psel/penable    | paddr, pwdata, prdata, pready
//
// Steps: a temperature or rejected item goes from decode to the final step; a humidity
//   item makes four passes through the one shared 30x30 multiplier (B*S,
//   S*(A-B*S), correction, reciprocal divide by 1e5) and the steps between.
// Reset: rst is synchronous, active high; clear sequencer, out_valid, stored temperature, registers.
// Stalls: hold a finished item in the result register while out_stall is high;
//   accept the next item meanwhile and park it in its last step until free.
module humidity_temperature_compensation #(
  parameter int RAW_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst,
  // input item channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [RAW_BITS-1:0]                 raw_value,
  // result item channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                result_kind,
  output logic                                accepted,
  output logic signed [htc_pkg::OUT_W-1:0]    value,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [htc_pkg::ADDR_W-1:0]          paddr,
  input  logic [htc_pkg::DATA_W-1:0]          pwdata,
  output logic [htc_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  htc_pkg::cfg_t       cfg;
  htc_pkg::seq_state_t seq_state, seq_state_next;

  // Captured item
  logic                kind_r;
  logic [RAW_BITS-1:0] raw_r;

  // Working registers
  logic signed [htc_pkg::ACC_W-1:0] acc, acc_next;
  logic                             neg, neg_next;
  logic                             res_ok, res_ok_next;
  logic signed [htc_pkg::OUT_W-1:0] res_value, res_value_next;
  logic signed [htc_pkg::T_W-1:0]   last_temperature, last_temperature_next;
  logic                             load_out;

  // Shared multiplier
  logic signed [htc_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [htc_pkg::PROD_W-1:0] prod;

  // Datapath helpers
  logic [htc_pkg::RAW_MAXW-1:0]      raw16;
  logic signed [htc_pkg::MUL_W-1:0]  s_ext;
  logic signed [htc_pkg::MUL_W-1:0]  coef_a, coef_b;
  logic [2:0]                        c_shift;
  logic                              temp_ok, hum_ok;
  logic [htc_pkg::T_W-1:0]           t_scaled;
  logic signed [htc_pkg::T_W-1:0]    t_new;
  logic signed [htc_pkg::T_W:0]      t_rel;
  logic [htc_pkg::ACC_W-1:0]         rnd, rnd_clamped;
  logic [htc_pkg::Y_W-1:0]           div_in;
  logic [htc_pkg::Q_W-1:0]           quot;
  logic signed [htc_pkg::T_W-1:0]    quot_s, quot_signed;

  htc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  htc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Take a new item only from idle; hold off during reset too.
  assign in_stall = rst || (seq_state != htc_pkg::S_IDLE);

  assign raw16   = htc_pkg::RAW_MAXW'(raw_r);
  assign s_ext   = $signed(htc_pkg::MUL_W'(raw_r));
  assign coef_a  = cfg.low_res ? htc_pkg::COEF_A_HI : htc_pkg::COEF_A_LO;
  assign coef_b  = cfg.low_res ? htc_pkg::COEF_B_HI : htc_pkg::COEF_B_LO;
  assign c_shift = cfg.low_res ? htc_pkg::C_SHIFT_HI : htc_pkg::C_SHIFT_LO;
  assign temp_ok = (raw16 <= htc_pkg::TEMP_RAW_LIMIT);
  assign hum_ok  = (raw16 <= htc_pkg::HUM_RAW_LIMIT);

  // Temperature: offset plus raw count, times four in the 12-bit mode.
  assign t_scaled = cfg.low_res ? {raw16, 2'b00} : {2'b00, raw16};
  assign t_new    = $signed(t_scaled) + htc_pkg::T_W'(cfg.temp_offset);

  // Correction factor (T - 25.00) scaled to hundredths.
  assign t_rel = (htc_pkg::T_W + 1)'(last_temperature) - htc_pkg::T_REF;

  // Round half away from zero on the magnitude, then clamp where the result
  // saturates anyway so the divide fits the multiplier.
  assign rnd         = acc[htc_pkg::ACC_W-1] ? $unsigned(htc_pkg::HALF - acc)
                                             : $unsigned(acc + htc_pkg::HALF);
  assign rnd_clamped = (rnd > htc_pkg::DIV_CLAMP) ? htc_pkg::DIV_CLAMP : rnd;
  assign div_in      = rnd_clamped[htc_pkg::PRE_SHIFT +: htc_pkg::Y_W];

  assign quot        = prod[htc_pkg::RECIP_SHIFT +: htc_pkg::Q_W];
  assign quot_s      = $signed({1'b0, quot});
  assign quot_signed = neg ? -quot_s : quot_s;

  always_comb begin
    seq_state_next        = seq_state;
    mul_a                 = '0;
    mul_b                 = '0;
    acc_next              = acc;
    neg_next              = neg;
    res_ok_next           = res_ok;
    res_value_next        = res_value;
    last_temperature_next = last_temperature;
    load_out              = 1'b0;
    case (seq_state)
      htc_pkg::S_IDLE: begin
        if (in_valid) begin
          seq_state_next = htc_pkg::S_DECODE;
        end
      end
      htc_pkg::S_DECODE: begin
        // Start B*S speculatively; drop it unless the item is humidity.
        mul_a = coef_b;
        mul_b = s_ext;
        if (kind_r == htc_pkg::KIND_TEMP) begin
          res_ok_next    = temp_ok;
          res_value_next = temp_ok ? htc_pkg::sat_out(t_new) : '0;
          if (temp_ok) begin
            last_temperature_next = t_new;
          end
          seq_state_next = htc_pkg::S_DONE;
        end else if (!hum_ok) begin
          res_ok_next    = 1'b0;
          res_value_next = '0;
          seq_state_next = htc_pkg::S_DONE;
        end else begin
          res_ok_next    = 1'b1;
          seq_state_next = htc_pkg::S_QUAD;
        end
      end
      htc_pkg::S_QUAD: begin
        mul_a          = s_ext;
        mul_b          = coef_a - $signed(prod[htc_pkg::MUL_W-1:0]);
        seq_state_next = htc_pkg::S_CORR;
      end
      htc_pkg::S_CORR: begin
        acc_next = htc_pkg::N_BIAS + htc_pkg::ACC_W'(prod);
        // Correction only when the stored temperature is above zero.
        mul_a = (last_temperature > 0) ? htc_pkg::MUL_W'(t_rel) : '0;
        mul_b = htc_pkg::T1_SCALED + $signed(htc_pkg::MUL_W'(raw_r) << c_shift);
        seq_state_next = htc_pkg::S_SUM;
      end
      htc_pkg::S_SUM: begin
        acc_next       = acc + htc_pkg::ACC_W'(prod);
        seq_state_next = htc_pkg::S_ROUND;
      end
      htc_pkg::S_ROUND: begin
        // Divide by 1e5 as a shift by 5 and a reciprocal multiply for 3125.
        neg_next       = acc[htc_pkg::ACC_W-1];
        mul_a          = $signed(htc_pkg::MUL_W'(div_in));
        mul_b          = htc_pkg::RECIP;
        seq_state_next = htc_pkg::S_SCALE;
      end
      htc_pkg::S_SCALE: begin
        res_value_next = htc_pkg::sat_out(quot_signed);
        seq_state_next = htc_pkg::S_DONE;
      end
      htc_pkg::S_DONE: begin
        // Hold here until the result register is free.
        if (!out_valid || !out_stall) begin
          load_out       = 1'b1;
          seq_state_next = htc_pkg::S_IDLE;
        end
      end
      default: begin
        seq_state_next = htc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state        <= htc_pkg::S_IDLE;
      last_temperature <= '0;
      out_valid        <= 1'b0;
    end else begin
      seq_state        <= seq_state_next;
      last_temperature <= last_temperature_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_r <= kind;
      raw_r  <= raw_value;
    end
    acc       <= acc_next;
    neg       <= neg_next;
    res_ok    <= res_ok_next;
    res_value <= res_value_next;
    if (load_out) begin
      result_kind <= kind_r;
      accepted    <= res_ok;
      value       <= res_value;
    end
  end

`include "humidity_temperature_compensation_assert.svh"

  `HTC_ASSERT_NEXT(a_accept_decodes, clk, rst, in_valid && !in_stall, seq_state == htc_pkg::S_DECODE, "accepted item did not enter decode")
  `HTC_ASSERT_SAME(a_reject_zero, clk, rst, out_valid && !accepted, value == '0, "rejected item carries a nonzero value")
  `HTC_ASSERT_SAME(a_result_from_done, clk, rst, $rose(out_valid), $past(seq_state) == htc_pkg::S_DONE, "result appeared outside the final step")
  `HTC_ASSERT_SAME(a_temp_store, clk, rst, !$past(rst) && (last_temperature != $past(last_temperature)), $past(seq_state == htc_pkg::S_DECODE && kind_r == htc_pkg::KIND_TEMP), "stored temperature changed without a temperature item")

endmodule

// ===== bench/tb.sv =====
module tb;
  import htc_pkg::*;

  localparam int RAW_W       = 14;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 12;
  localparam int PHASES      = 7;
  localparam int RANDOM_PER_PHASE = 230;
  localparam int DIRECTED_N  = 19;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  // One converted reading as it leaves the block.
  typedef struct {
    logic                     res_kind;
    logic                     ok;
    logic signed [OUT_W-1:0]  value;
  } reading_t;

  // Conversion predictor plus the queue of readings still owed by the block.
  class conversion_scoreboard;
    logic                     low_res;
    logic signed [OFFS_W-1:0] offset;
    logic signed [T_W-1:0]    stored_temp;
    reading_t                 owed_readings[$];
    int                       fault_count;

    function new();
      low_res     = 1'b0;
      offset      = OFFSET_RESET;
      stored_temp = '0;
      fault_count = 0;
    endfunction

    function void write_register(logic idx, logic [DATA_W-1:0] data);
      if (idx == REG_LOW_RES) begin
        low_res = data[0];
      end else begin
        offset = data[OFFS_W-1:0];
      end
    endfunction

    function int pending();
      return owed_readings.size();
    endfunction

    // Work out the reading caused by one accepted raw word.
    function void note_item(logic k, logic [RAW_W-1:0] raw);
      reading_t r;
      longint   s;
      longint   n;
      longint   q;
      longint   t;
      longint   a;
      longint   b;
      longint   c;
      s = raw;
      q = 0;
      r.res_kind = k;
      r.ok = 1'b0;
      if (k == KIND_TEMP) begin
        if (s <= TEMP_RAW_LIMIT) begin
          t = longint'(offset) + (low_res ? 4 : 1) * s;
          stored_temp = t[T_W-1:0];
          q = t;
          r.ok = 1'b1;
        end
      end else begin
        if (s <= HUM_RAW_LIMIT) begin
          a = low_res ? 6480000 : 405000;
          b = low_res ? 7200 : 28;
          c = low_res ? 128 : 8;
          n = -40000000 + a * s - b * s * s;
          // correction only when the last temperature is above zero
          if (stored_temp > 0) begin
            n += (longint'(stored_temp) - 2500) * (1000 + c * s);
          end
          // round half away from zero
          if (n >= 0) begin
            q = (n + 50000) / 100000;
          end else begin
            q = -((-n + 50000) / 100000);
          end
          r.ok = 1'b1;
        end
      end
      if (q > 65535) begin
        q = 65535;
      end else if (q < -65536) begin
        q = -65536;
      end
      r.value = q[OUT_W-1:0];
      owed_readings.push_back(r);
    endfunction

    function void check_result(logic k, logic ok, logic signed [OUT_W-1:0] v);
      reading_t e;
      if (owed_readings.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected reading: kind=%0d accepted=%0d value=%0d", k, ok, v);
        end
        return;
      end
      e = owed_readings.pop_front();
      if (k !== e.res_kind || ok !== e.ok || v !== e.value) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("reading mismatch: kind %0d/%0d accepted %0d/%0d value %0d/%0d (exp/got)",
                   e.res_kind, k, e.ok, ok, e.value, v);
        end
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic                    kind;
  logic [RAW_W-1:0]        raw_value;
  logic                    out_valid;
  logic                    out_stall;
  logic                    result_kind;
  logic                    accepted;
  logic signed [OUT_W-1:0] value;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  conversion_scoreboard sb = new();
  int cycle_count = 0;
  int burst_left  = 0;

  humidity_temperature_compensation #(.RAW_BITS(RAW_W)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .raw_value(raw_value),
    .out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
    .accepted(accepted), .value(value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung block well past the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sample both channels at the rising edge; outputs still hold pre-edge values here.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sb.note_item(kind, raw_value);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(result_kind, accepted, value);
    end
  end

  // Receiver back-pressure: switch between spans of no stall, coin-flip stall,
  // a periodic on/off pattern and heavy stall, each span of random length.
  initial begin
    stall_mode_t mode;
    int          span;
    int          tick;
    int          period;
    out_stall = 1'b0;
    tick = 0;
    forever begin
      mode   = stall_mode_t'($urandom_range(0, 3));
      span   = $urandom_range(10, 60);
      period = $urandom_range(2, 9);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          STALL_NONE:     out_stall = 1'b0;
          STALL_COIN:     out_stall = 1'($urandom_range(0, 1));
          STALL_PERIODIC: out_stall = (tick % period) < (period / 2);
          default:        out_stall = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Drive one raw word; enter at a falling edge, leave at the falling edge after accept.
  // The sender works in bursts; open a gap whenever the current burst is used up.
  task automatic send_item(logic k, logic [RAW_W-1:0] raw);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    in_valid  = 1'b1;
    kind      = k;
    raw_value = raw;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
  endtask

  // Mostly plausible readings, with near-zero temperatures, humidity words at
  // the plausibility edge, and a share of out-of-range raw words.
  task automatic send_random_item();
    logic             k;
    logic [RAW_W-1:0] raw;
    int               pick;
    k    = ($urandom_range(0, 9) < 4) ? KIND_TEMP : KIND_HUM;
    pick = $urandom_range(0, 99);
    if (k == KIND_TEMP) begin
      if (pick < 12) begin
        raw = RAW_W'($urandom_range(TEMP_RAW_LIMIT + 1, 16383));
      end else if (pick < 20) begin
        raw = RAW_W'($urandom_range(3900, 4100));
      end else if (pick < 25) begin
        raw = RAW_W'($urandom_range(950, 1050));
      end else begin
        raw = RAW_W'($urandom_range(0, TEMP_RAW_LIMIT));
      end
    end else begin
      if (pick < 12) begin
        raw = RAW_W'($urandom_range(HUM_RAW_LIMIT + 1, 16383));
      end else if (pick < 20) begin
        raw = RAW_W'($urandom_range(HUM_RAW_LIMIT - 8, HUM_RAW_LIMIT));
      end else begin
        raw = RAW_W'($urandom_range(0, HUM_RAW_LIMIT));
      end
    end
    send_item(k, raw);
  endtask

  // Register write with a setup phase, then an access phase.
  task automatic write_reg(logic idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    sb.write_register(idx, data);
  endtask

  // Hold until every owed reading is back, then let the sequencer settle.
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic                     dir_kind[DIRECTED_N];
    logic [RAW_W-1:0]         dir_raw[DIRECTED_N];
    logic                     phase_low_res[PHASES];
    logic signed [OFFS_W-1:0] phase_offset[PHASES];

    // Directed words: humidity before any temperature, plausibility edges on
    // both kinds, a negative, a zero, a 25-degree and a just-positive stored
    // temperature, each followed by humidity to show the correction switch.
    dir_kind = '{
      KIND_HUM, KIND_HUM, KIND_HUM, KIND_HUM, KIND_TEMP, KIND_HUM, KIND_TEMP,
      KIND_HUM, KIND_HUM, KIND_HUM, KIND_TEMP, KIND_TEMP, KIND_HUM, KIND_TEMP,
      KIND_HUM, KIND_TEMP, KIND_HUM, KIND_TEMP, KIND_HUM};
    dir_raw = '{
      0, 2567, 2568, 16383, 0, 1000, 14000,
      0, 2567, 450, 14001, 16383, 1000, 6466,
      1500, 3967, 2000, 3966, 2000};

    rst       = 1'b1;
    in_valid  = 1'b0;
    kind      = KIND_TEMP;
    raw_value = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;

    // Register settings per phase: both resolutions, the plausible offset
    // range ends, and the 13-bit extremes.
    phase_low_res = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_offset  = '{-13'sd4000, -13'sd3955, 13'sd4095, -13'sd4096, -13'sd3966,
                      -13'sd3966, -13'sd3966};
    phase_offset[4] = OFFS_W'($urandom_range(0, 45) - 4000);
    phase_offset[5] = OFFS_W'($urandom_range(0, 8191));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Run the directed words on reset register values.
    for (int i = 0; i < DIRECTED_N; i++) begin
      send_item(dir_kind[i], dir_raw[i]);
    end
    in_valid = 1'b0;
    wait_idle();

    // Re-program both registers while idle, then stream random words.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_LOW_RES, {31'b0, phase_low_res[p]});
      write_reg(REG_TEMP_OFFSET, {{(DATA_W - OFFS_W){phase_offset[p][OFFS_W-1]}},
                                  phase_offset[p]});
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        send_random_item();
      end
      in_valid = 1'b0;
      wait_idle();
    end

    if (sb.fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/htc_pkg.sv
rtl/core/htc_mul.sv
rtl/core/htc_cfg.sv
rtl/core/humidity_temperature_compensation.sv
bench/tb.sv
